>>> hw/rtl/cpio_newc_stream_walker_assert.svh
// Assertion macros for the cpio newc stream walker.
// Needs i_clk and i_rst_n in the scope that uses them.
`ifndef CPIO_NEWC_STREAM_WALKER_ASSERT_SVH
`define CPIO_NEWC_STREAM_WALKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CNSW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CNSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cnsw_pkg.sv
// Shared constants, result struct and hex digit decode for the cpio newc walker.
// No dependencies.
package cnsw_pkg;

    localparam int unsigned HEADER_BYTES = 110;

    localparam logic [6:0] HDR_LAST        = 7'(HEADER_BYTES - 1);
    localparam logic [6:0] OFF_FILESIZE    = 7'd54;
    localparam logic [6:0] OFF_FILESIZE_END = 7'd62;
    localparam logic [6:0] OFF_NAMESIZE    = 7'd94;
    localparam logic [6:0] OFF_NAMESIZE_END = 7'd102;
    localparam logic [6:0] OFF_MODE4       = 7'd18;
    localparam logic [6:0] OFF_MODE7       = 7'd21;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_EIGHT = 8'h38;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;

    localparam logic [2:0] CLS_HEADER      = 3'd0;
    localparam logic [2:0] CLS_NAME        = 3'd1;
    localparam logic [2:0] CLS_NAME_PAD    = 3'd2;
    localparam logic [2:0] CLS_CONTENT     = 3'd3;
    localparam logic [2:0] CLS_CONTENT_PAD = 3'd4;
    localparam logic [2:0] CLS_AFTER_END   = 3'd5;

    localparam logic [15:0] ENTRY_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [15:0] entry_index;
        logic        is_directory;
        logic        entry_start;
        logic        content_end;
        logic        archive_done;
    } t_result;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            d = c - CHAR_UA + 8'd10;
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            d = c - CHAR_LA + 8'd10;
        end
        return d[3:0];
    endfunction

endpackage

>>> hw/rtl/cnsw_tracker.sv
// Archive position tracker: holds the parse state, classifies one byte a cycle while i_adv is high.
// Depends on cnsw_pkg.
module cnsw_tracker
    import cnsw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_NAME_PAD,
        PH_CONTENT,
        PH_CONTENT_PAD,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [6:0]  r_hdr_off, n_hdr_off;
    logic [31:0] r_remaining, n_remaining;
    logic [31:0] r_name_len, n_name_len;
    logic [31:0] r_content_len, n_content_len;
    logic [1:0]  r_align, n_align;
    logic        r_file, n_file;
    logic        r_trailer, n_trailer;
    logic [15:0] r_entry, n_entry;

    logic [3:0]  hex;
    logic [31:0] rem_dec;
    logic        go_after_name, go_enter_content, go_after_content, go_next;

    always_comb begin
        n_phase       = r_phase;
        n_hdr_off     = r_hdr_off;
        n_remaining   = r_remaining;
        n_name_len    = r_name_len;
        n_content_len = r_content_len;
        n_align       = r_align + 2'd1;
        n_file        = r_file;
        n_trailer     = r_trailer;
        n_entry       = r_entry;

        hex     = hex_nibble(i_byte);
        rem_dec = r_remaining - 32'd1;

        go_after_name    = 1'b0;
        go_enter_content = 1'b0;
        go_after_content = 1'b0;
        go_next          = 1'b0;

        o_res.byte_class   = CLS_AFTER_END;
        o_res.entry_index  = r_entry;
        o_res.is_directory = 1'b0;
        o_res.entry_start  = 1'b0;
        o_res.content_end  = 1'b0;

        case (r_phase)
            PH_HEADER: begin
                o_res.byte_class = CLS_HEADER;
                if (r_hdr_off == 7'd0) begin
                    o_res.entry_start = 1'b1;
                    n_name_len        = 32'd0;
                    n_content_len     = 32'd0;
                    n_file            = 1'b0;
                    n_trailer         = 1'b0;
                end
                if (r_hdr_off >= OFF_FILESIZE && r_hdr_off < OFF_FILESIZE_END) begin
                    n_content_len = {n_content_len[27:0], hex};
                end
                if (r_hdr_off >= OFF_NAMESIZE && r_hdr_off < OFF_NAMESIZE_END) begin
                    n_name_len = {n_name_len[27:0], hex};
                end
                if (r_hdr_off == OFF_MODE4) begin
                    n_file = (i_byte == CHAR_EIGHT);
                end
                if (r_hdr_off == OFF_MODE7) begin
                    n_trailer = (i_byte == CHAR_ZERO);
                end
                if (r_hdr_off >= HDR_LAST) begin
                    n_hdr_off = 7'd0;
                    if (n_trailer) begin
                        n_phase = PH_DONE;
                    end else if (n_name_len != 32'd0) begin
                        n_remaining = n_name_len;
                        n_phase     = PH_NAME;
                    end else begin
                        go_after_name = 1'b1;
                    end
                end else begin
                    n_hdr_off = r_hdr_off + 7'd1;
                end
            end
            PH_NAME: begin
                o_res.byte_class   = CLS_NAME;
                o_res.is_directory = !r_file;
                n_remaining        = rem_dec;
                if (rem_dec == 32'd0) begin
                    go_after_name = 1'b1;
                end
            end
            PH_NAME_PAD: begin
                o_res.byte_class   = CLS_NAME_PAD;
                o_res.is_directory = !r_file;
                if (n_align == 2'd0) begin
                    go_enter_content = 1'b1;
                end
            end
            PH_CONTENT: begin
                o_res.byte_class   = CLS_CONTENT;
                o_res.is_directory = !r_file;
                n_remaining        = rem_dec;
                if (rem_dec == 32'd0) begin
                    o_res.content_end = 1'b1;
                    go_after_content  = 1'b1;
                end
            end
            PH_CONTENT_PAD: begin
                o_res.byte_class   = CLS_CONTENT_PAD;
                o_res.is_directory = !r_file;
                if (n_align == 2'd0) begin
                    go_next = 1'b1;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        if (go_after_name) begin
            if (n_align != 2'd0) begin
                n_phase = PH_NAME_PAD;
            end else begin
                go_enter_content = 1'b1;
            end
        end
        if (go_enter_content) begin
            if (n_content_len != 32'd0) begin
                n_remaining = n_content_len;
                n_phase     = PH_CONTENT;
            end else begin
                go_after_content = 1'b1;
            end
        end
        if (go_after_content) begin
            if (n_align != 2'd0) begin
                n_phase = PH_CONTENT_PAD;
            end else begin
                go_next = 1'b1;
            end
        end
        if (go_next) begin
            if (r_entry != ENTRY_MAX) begin
                n_entry = r_entry + 16'd1;
            end
            n_phase   = PH_HEADER;
            n_hdr_off = 7'd0;
        end

        o_res.archive_done = (n_phase == PH_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_hdr_off     <= 7'd0;
            r_remaining   <= 32'd0;
            r_name_len    <= 32'd0;
            r_content_len <= 32'd0;
            r_align       <= 2'd0;
            r_file        <= 1'b0;
            r_trailer     <= 1'b0;
            r_entry       <= 16'd0;
        end else if (i_adv) begin
            r_phase       <= n_phase;
            r_hdr_off     <= n_hdr_off;
            r_remaining   <= n_remaining;
            r_name_len    <= n_name_len;
            r_content_len <= n_content_len;
            r_align       <= n_align;
            r_file        <= n_file;
            r_trailer     <= n_trailer;
            r_entry       <= n_entry;
        end
    end

endmodule

>>> hw/rtl/cpio_newc_stream_walker.sv
// cpio newc stream walker: input register, tracker, result register.
// An accepted word passes the input register and then the result register
// before it is offered on the result side. Throughput: one word per cycle;
// the input register and the parse state advance whenever the result
// register is empty or being taken. Synchronous active-low reset clears both
// valid flags and the parse state to the first header byte of entry 0.
// Depends on cnsw_pkg, cnsw_tracker and cpio_newc_stream_walker_assert.svh.
`include "cpio_newc_stream_walker_assert.svh"
module cpio_newc_stream_walker
    import cnsw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_byte_out,
    output logic [2:0]  o_byte_class,
    output logic [15:0] o_entry_index,
    output logic        o_is_directory,
    output logic        o_entry_start,
    output logic        o_content_end,
    output logic        o_archive_done
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_result    r_out_res;

    logic       out_free;
    logic       adv;
    t_result    res;

    assign out_free   = !r_out_valid || i_out_ready;
    assign adv        = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || adv;

    cnsw_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (adv) begin
            r_out_byte <= r_in_byte;
            r_out_res  <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_out     = r_out_byte;
    assign o_byte_class   = r_out_res.byte_class;
    assign o_entry_index  = r_out_res.entry_index;
    assign o_is_directory = r_out_res.is_directory;
    assign o_entry_start  = r_out_res.entry_start;
    assign o_content_end  = r_out_res.content_end;
    assign o_archive_done = r_out_res.archive_done;

    `CNSW_ASSERT_IMPL(a_start_in_header, o_out_valid && o_entry_start, o_byte_class == CLS_HEADER, "entry_start outside header")
    `CNSW_ASSERT_IMPL(a_cend_in_content, o_out_valid && o_content_end, o_byte_class == CLS_CONTENT, "content_end outside content")
    `CNSW_ASSERT_IMPL(a_after_end_done, o_out_valid && o_byte_class == CLS_AFTER_END, o_archive_done, "after-end word without archive_done")
    `CNSW_ASSERT_NEXT(a_done_sticky, o_out_valid && i_out_ready && o_archive_done, !o_out_valid || o_archive_done, "archive_done dropped")

endmodule
